[src/irng_pkg.sv]
`timescale 1ns / 1ps

package irng_pkg;

	// default sizes
	localparam int SAMPLE_WIDTH_DEF    = 24;
	localparam int PHASE_FRAC_BITS_DEF = 32;

	// interpolation phase resolution and output gain (0.815 in Q16)
	localparam int          XQ_BITS    = 24;
	localparam int          XQ_W       = XQ_BITS + 1;
	localparam int          MUL_B_W    = XQ_W + 1;
	localparam logic [16:0] GAIN_Q16   = 17'd53412;
	localparam int          GAIN_SHIFT = 17;

	// random source: Galois LFSR x^32+x^22+x^2+x+1, shifting right
	localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
	localparam logic [31:0] LFSR_RESET = 32'd1;

	// configuration register map
	localparam int          CFG_IDX_W           = 3;
	localparam int          CFG_DATA_W          = 35;
	localparam logic [2:0]  CFG_INTERP_ON       = 3'd0;
	localparam logic [2:0]  CFG_RATE_SOURCE     = 3'd1;
	localparam logic [2:0]  CFG_PHASE_INCREMENT = 3'd2;
	localparam logic [2:0]  CFG_INV_SAMPLE_RATE = 3'd3;
	localparam logic [2:0]  CFG_LFSR_SEED       = 3'd4;
	localparam logic [34:0] INV_SR_RESET        = 35'd6382652534;

	// depth of the front-to-back and result queues
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic        interp_on;
		logic        rate_source;
		logic [31:0] phase_increment;
		logic [34:0] inv_sample_rate;
	} cfg_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] cur);
		logic [31:0] nxt;
		nxt = {1'b0, cur[31:1]};
		if (cur[0]) begin
			nxt = nxt ^ LFSR_TAPS;
		end
		return nxt;
	endfunction

endpackage

[src/interpolated_random_noise_generator_core.sv]
`timescale 1ns / 1ps

// Interpolated random noise generator. Each pushed beat is one audio sample tick carrying a
// signed Q16.16 rate; each popped beat is one Q1.(SAMPLE_WIDTH-1) noise sample. New random
// points come from a 32-bit LFSR whenever the phase passes 1.0, and the output is either the
// held point or 0.815 times a four-point Hermite curve through the middle two of the last
// four points. A zero rate (per-sample mode) or a zero fixed increment gives a zero sample
// and leaves all state alone. The front passes the fixed increment on, or forms the
// per-sample step from one 32x32 product plus a 32x3 one, then the saturating sum, then
// the hand-over to the queue. The back pushes a zero for a zero rate; otherwise it steps
// the phase, then pushes the held point in sample-and-hold, or runs Horner with
// interpolation: three products and the gain a fourth, all on one shared multiplier, each
// product registered before its add. Neither side takes a new tick until the last is
// handed on. Configuration writes are always ready and must be made while the block is
// idle; writing the seed also reloads the LFSR (a seed of zero loads one).

module interpolated_random_noise_generator_core #(
	parameter int SAMPLE_WIDTH    = irng_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_FRAC_BITS = irng_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick input
	input  logic                              push,
	output logic                              full,
	input  logic signed [31:0]                rate_in,
	// sample output
	output logic                              empty,
	input  logic                              pop,
	output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irng_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irng_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IW = PHASE_FRAC_BITS + 1;

	irng_pkg::cfg_t cfg_q;
	logic           seed_load;
	logic           cfg_wr;

	logic          mid_push;
	logic [IW-1:0] mid_wdata;
	logic          mid_pop;
	logic [IW-1:0] mid_rdata;
	logic          mid_full;
	logic          mid_empty;

	logic                    res_push;
	logic [SAMPLE_WIDTH-1:0] res_wdata;
	logic [SAMPLE_WIDTH-1:0] res_rdata;
	logic                    res_full;

	// register file; writes beyond the map are dropped
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign seed_load = cfg_wr && (cfg_index == irng_pkg::CFG_LFSR_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interp_on       <= 1'b1;
			cfg_q.rate_source     <= 1'b0;
			cfg_q.phase_increment <= '0;
			cfg_q.inv_sample_rate <= irng_pkg::INV_SR_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				irng_pkg::CFG_INTERP_ON:       cfg_q.interp_on       <= cfg_data[0];
				irng_pkg::CFG_RATE_SOURCE:     cfg_q.rate_source     <= cfg_data[0];
				irng_pkg::CFG_PHASE_INCREMENT: cfg_q.phase_increment <= cfg_data[31:0];
				irng_pkg::CFG_INV_SAMPLE_RATE: cfg_q.inv_sample_rate <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: tick in, phase step out
	irng_front #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.full   (full),
		.rate_in(rate_in),
		.q_full (mid_full),
		.q_push (mid_push),
		.q_item (mid_wdata)
	);

	// decouples the step calculation from the interpolator
	irng_fifo #(
		.WIDTH(IW),
		.DEPTH(irng_pkg::QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_push),
		.wr_data(mid_wdata),
		.rd_en  (mid_pop),
		.rd_data(mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	// back: history, LFSR and Hermite evaluation
	irng_back #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.seed_load (seed_load),
		.seed_value(cfg_data[31:0]),
		.in_empty  (mid_empty),
		.in_pop    (mid_pop),
		.in_item   (mid_rdata),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_data  (res_wdata)
	);

	// result queue: the back keeps working while a sample waits to be popped
	irng_fifo #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(irng_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_wdata),
		.rd_en  (pop),
		.rd_data(res_rdata),
		.full   (res_full),
		.empty  (empty)
	);

	assign sample_out = res_rdata;

endmodule

[src/irng_fifo.sv]
`timescale 1ns / 1ps

// small register queue, first word fall-through
module irng_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = irng_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[src/irng_front.sv]
`timescale 1ns / 1ps

// takes a tick, works out the phase step and the zero-rate flag
module irng_front #(
	parameter int PHASE_FRAC_BITS = irng_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  irng_pkg::cfg_t           cfg,
	input  logic                     push,
	output logic                     full,
	input  logic signed [31:0]       rate_in,
	input  logic                     q_full,
	output logic                     q_push,
	output logic [PHASE_FRAC_BITS:0] q_item
);

	localparam int PFB = PHASE_FRAC_BITS;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_PUSH} fstate_t;

	fstate_t        state_q;
	logic [31:0]    mag_q;
	logic           zero_q;
	logic [63:0]    plo_q;
	logic [34:0]    phi_q;
	logic [PFB-1:0] inc_q;

	logic [31:0]    rate_abs;
	logic [PFB-1:0] fixed_inc;
	logic [66:0]    full_prod;
	logic [PFB-1:0] rate_inc;

	assign rate_abs = rate_in[31] ? (~rate_in + 32'd1) : rate_in;

	generate
		if (PFB >= 32) begin : g_fix_wide
			assign fixed_inc = PFB'({cfg.phase_increment, (PFB - 32 + 1)'(0)} >> 1);
		end else begin : g_fix_narrow
			assign fixed_inc = cfg.phase_increment[31 -: PFB];
		end
	endgenerate

	// |rate| * inv_sample_rate, saturating below 1.0
	assign full_prod = {phi_q, 32'd0} + {3'd0, plo_q};
	assign rate_inc  = (|full_prod[66:64]) ? '1 : full_prod[63 -: PFB];

	assign full   = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_item = {zero_q, inc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mag_q   <= '0;
			zero_q  <= 1'b0;
			plo_q   <= '0;
			phi_q   <= '0;
			inc_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						if (cfg.rate_source) begin
							mag_q   <= rate_abs;
							zero_q  <= (rate_in == '0);
							state_q <= F_MUL;
						end else begin
							zero_q  <= (cfg.phase_increment == '0);
							inc_q   <= fixed_inc;
							state_q <= F_PUSH;
						end
					end
				end
				F_MUL: begin
					plo_q   <= 64'(mag_q) * 64'(cfg.inv_sample_rate[31:0]);
					phi_q   <= 35'(mag_q) * 35'(cfg.inv_sample_rate[34:32]);
					state_q <= F_SUM;
				end
				F_SUM: begin
					inc_q   <= rate_inc;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

[src/irng_back.sv]
`timescale 1ns / 1ps

// phase and history update, Hermite by Horner on one shared multiplier
module irng_back #(
	parameter int SAMPLE_WIDTH    = irng_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_FRAC_BITS = irng_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  irng_pkg::cfg_t           cfg,
	input  logic                     seed_load,
	input  logic [31:0]              seed_value,
	input  logic                     in_empty,
	output logic                     in_pop,
	input  logic [PHASE_FRAC_BITS:0] in_item,
	input  logic                     out_full,
	output logic                     out_push,
	output logic [SAMPLE_WIDTH-1:0]  out_data
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int PFB = PHASE_FRAC_BITS;
	localparam int W   = SW + 9;
	localparam int MBW = irng_pkg::MUL_B_W;
	localparam int P   = W + MBW;
	localparam logic signed [P-1:0] SMAX  = P'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [P-1:0] SMIN  = -SMAX - P'(1);
	localparam logic signed [P-1:0] R_OFS = P'(64'sd1 <<< (irng_pkg::GAIN_SHIFT - 1));

	typedef enum logic [2:0] {B_IDLE, B_UPD, B_PREP, B_MUL, B_ADD, B_PUSH} bstate_t;

	bstate_t               state_q;
	logic [PFB:0]          phase_q;
	logic [PFB-1:0]        inc_q;
	logic signed [SW-1:0]  y0_q, y1_q, y2_q, y3_q;
	logic [31:0]           lfsr_q;
	logic signed [W-1:0]   d0_q, d1_q, d2_q;
	logic signed [W-1:0]   acc_q;
	logic signed [P-1:0]   prod_q;
	logic [1:0]            step_q;
	logic [SW-1:0]         res_q;

	logic [31:0]             lfsr_nxt;
	logic signed [SW-1:0]    new_pt;
	logic [irng_pkg::XQ_BITS:0] xq;
	logic signed [MBW-1:0]   mul_b;
	logic signed [P-1:0]     prod_d;
	logic signed [W-1:0]     sh;
	logic signed [P-1:0]     rnd;
	logic signed [W-1:0]     e0, e1, e2, e3;

	assign lfsr_nxt = irng_pkg::lfsr_next(lfsr_q);
	assign new_pt   = lfsr_nxt[31 -: SW];

	generate
		if (PFB >= irng_pkg::XQ_BITS) begin : g_xq_trunc
			assign xq = phase_q[PFB -: irng_pkg::XQ_W];
		end else begin : g_xq_ext
			assign xq = {phase_q, (irng_pkg::XQ_BITS - PFB)'(0)};
		end
	endgenerate

	assign e0 = W'(y0_q);
	assign e1 = W'(y1_q);
	assign e2 = W'(y2_q);
	assign e3 = W'(y3_q);

	// last pass applies the output gain
	assign mul_b  = (step_q == 2'd3) ? MBW'(irng_pkg::GAIN_Q16) : MBW'({1'b0, xq});
	assign prod_d = acc_q * mul_b;
	assign sh     = W'(prod_q >>> irng_pkg::XQ_BITS);
	assign rnd    = (prod_q + R_OFS) >>> irng_pkg::GAIN_SHIFT;

	assign in_pop   = (state_q == B_IDLE) && !in_empty;
	assign out_push = (state_q == B_PUSH) && !out_full;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			phase_q <= '0;
			inc_q   <= '0;
			y0_q    <= '0;
			y1_q    <= '0;
			y2_q    <= '0;
			y3_q    <= '0;
			lfsr_q  <= irng_pkg::LFSR_RESET;
			d0_q    <= '0;
			d1_q    <= '0;
			d2_q    <= '0;
			acc_q   <= '0;
			prod_q  <= '0;
			step_q  <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!in_empty) begin
						inc_q <= in_item[PFB-1:0];
						if (in_item[PFB]) begin
							res_q   <= '0;
							state_q <= B_PUSH;
						end else begin
							state_q <= B_UPD;
						end
					end
				end
				B_UPD: begin
					// drop the integer part and step the phase
					phase_q <= {1'b0, phase_q[PFB-1:0]} + {1'b0, inc_q};
					if (phase_q[PFB]) begin
						lfsr_q <= lfsr_nxt;
						if (cfg.interp_on) begin
							y0_q <= y1_q;
							y1_q <= y2_q;
							y2_q <= y3_q;
							y3_q <= new_pt;
						end else begin
							y1_q <= new_pt;
						end
					end
					state_q <= B_PREP;
				end
				B_PREP: begin
					if (!cfg.interp_on) begin
						res_q   <= y1_q;
						state_q <= B_PUSH;
					end else begin
						d0_q    <= e1 <<< 1;
						d1_q    <= e2 - e0;
						d2_q    <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
						acc_q   <= ((e1 - e2) <<< 1) + (e1 - e2) + e3 - e0;
						step_q  <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					prod_q  <= prod_d;
					state_q <= B_ADD;
				end
				B_ADD: begin
					case (step_q)
						2'd0: acc_q <= sh + d2_q;
						2'd1: acc_q <= sh + d1_q;
						2'd2: acc_q <= sh + d0_q;
						default: begin
							if (rnd > SMAX) begin
								res_q <= SMAX[SW-1:0];
							end else if (rnd < SMIN) begin
								res_q <= SMIN[SW-1:0];
							end else begin
								res_q <= rnd[SW-1:0];
							end
						end
					endcase
					if (step_q == 2'd3) begin
						state_q <= B_PUSH;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= B_MUL;
					end
				end
				B_PUSH: begin
					if (!out_full) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			// the user must make seed writes only while idle; the block itself does not enforce it
			if (seed_load) begin
				lfsr_q <= (seed_value == '0) ? irng_pkg::LFSR_RESET : seed_value;
			end
		end
	end

endmodule
